// ===== rtl/orwr_pkg.sv =====
// shared types and constants for the overwrite ring buffer window read unit
`timescale 1ns / 1ps
`default_nettype none
package orwr_pkg;

  localparam int SAMPLE_W     = 32;
  localparam int COUNT_W      = 7;
  localparam int OPCODE_W     = 2;
  localparam int CAPACITY_DEF = 64;

  typedef enum logic [OPCODE_W-1:0] {
    OP_WRITE    = 2'd0,
    OP_READ_N   = 2'd1,
    OP_READ_ALL = 2'd2,
    OP_UNUSED   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STAT,
    ST_SKIP,
    ST_EMIT
  } state_t;

  // control from the sequencer to the chain of cells
  typedef struct packed {
    logic shift;
    logic take_input;
  } chain_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/orwr_if.sv =====
// item channels of the ring buffer: command side and result side
`timescale 1ns / 1ps
`default_nettype none
interface orwr_cmd_if
  import orwr_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic [OPCODE_W-1:0]        opcode;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic [COUNT_W-1:0]         read_count;

  modport source (output valid, opcode, sample_in, read_count, input ready);
  modport sink (input valid, opcode, sample_in, read_count, output ready);
endinterface

interface orwr_res_if
  import orwr_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       is_data;
  logic                       last_of_run;
  logic [COUNT_W-1:0]         fill_level;
  logic                       buffer_empty;
  logic                       buffer_full;

  modport source (output valid, sample_out, is_data, last_of_run, fill_level,
                  buffer_empty, buffer_full, input ready);
  modport sink (input valid, sample_out, is_data, last_of_run, fill_level,
                buffer_empty, buffer_full, output ready);
endinterface
`default_nettype wire

// ===== rtl/orwr_cell.sv =====
// one storage cell of the sample chain
`timescale 1ns / 1ps
`default_nettype none
module orwr_cell
  import orwr_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                shift,
  input  wire logic [SAMPLE_W-1:0] d,
  output logic      [SAMPLE_W-1:0] q
);

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/orwr_chain.sv =====
// chain of sample cells: newest at cell 0, rotates through the tail for read-out
`timescale 1ns / 1ps
`default_nettype none
module orwr_chain
  import orwr_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic                clk,
  input  wire chain_ctrl_t         ctrl,
  input  wire logic [SAMPLE_W-1:0] sample_in,
  output logic      [SAMPLE_W-1:0] tap
);

  logic [SAMPLE_W-1:0] cell_q [CAPACITY];
  logic [SAMPLE_W-1:0] head_d;

  // a write pushes a new sample in, a rotation wraps the tail back to the head
  assign head_d = ctrl.take_input ? sample_in : cell_q[CAPACITY-1];
  assign tap    = cell_q[CAPACITY-1];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      orwr_cell u_cell (
        .clk   (clk),
        .shift (ctrl.shift),
        .d     (head_d),
        .q     (cell_q[i])
      );
    end else begin : g_body
      orwr_cell u_cell (
        .clk   (clk),
        .shift (ctrl.shift),
        .d     (cell_q[i-1]),
        .q     (cell_q[i])
      );
    end
  end

endmodule
`default_nettype wire

// ===== rtl/overwrite_ring_buffer_window_read_unit.sv =====
// Overwrite-oldest sample ring buffer built as a circulating chain of cells.
// A write shifts the sample into the head cell (the oldest falls off the tail
// when full) and returns one status item; the unit then waits in ST_STAT until
// the result register can take the item, loads it and goes back to ST_IDLE
// for the next item. A read of N samples (N = fill for read-all, else
// min(read_count, fill)) turns the whole chain once around through the tail
// cell, which is the only read tap: ST_SKIP rotates the chain until the oldest
// of the N samples reaches the tap, then ST_EMIT gives one sample item per
// cycle while the result side does not stall. Reads of nothing and the unused
// opcode give one status item through ST_STAT. One item is worked on at a
// time; the result register lets the next item be accepted while the final
// result still waits.
`timescale 1ns / 1ps
`default_nettype none
module overwrite_ring_buffer_window_read_unit
  import orwr_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  orwr_cmd_if.sink  cmd,
  orwr_res_if.source res
);

  localparam logic [COUNT_W-1:0] CAP = COUNT_W'(CAPACITY);

  state_t             state, state_next;
  logic [COUNT_W-1:0] fill, fill_next;
  logic [COUNT_W-1:0] skip, skip_next;
  logic [COUNT_W-1:0] emit, emit_next;
  logic [COUNT_W-1:0] count;
  chain_ctrl_t        ctrl;
  logic [SAMPLE_W-1:0] tap;

  logic                res_valid;
  logic                load;
  logic [SAMPLE_W-1:0] load_sample;
  logic                load_data;
  logic                load_last;
  logic                can_load;

  orwr_chain #(
    .CAPACITY (CAPACITY)
  ) u_chain (
    .clk       (clk),
    .ctrl      (ctrl),
    .sample_in (cmd.sample_in),
    .tap       (tap)
  );

  assign cmd.ready = (state == ST_IDLE);
  assign can_load  = !res_valid || res.ready;

  // window length after clamping to the fill level
  assign count = (opcode_t'(cmd.opcode) == OP_READ_N && cmd.read_count < fill) ?
                 cmd.read_count : fill;

  always_comb begin
    state_next      = state;
    fill_next       = fill;
    skip_next       = skip;
    emit_next       = emit;
    ctrl.shift      = 1'b0;
    ctrl.take_input = 1'b0;
    load            = 1'b0;
    load_sample     = '0;
    load_data       = 1'b0;
    load_last       = 1'b1;
    unique case (state)
      ST_IDLE: begin
        if (cmd.valid) begin
          case (opcode_t'(cmd.opcode))
            OP_WRITE: begin
              ctrl.shift      = 1'b1;
              ctrl.take_input = 1'b1;
              if (fill != CAP) begin
                fill_next = fill + COUNT_W'(1);
              end
              state_next = ST_STAT;
            end
            OP_READ_N, OP_READ_ALL: begin
              if (count == '0) begin
                state_next = ST_STAT;
              end else begin
                skip_next  = CAP - count;
                emit_next  = count;
                state_next = (count == CAP) ? ST_EMIT : ST_SKIP;
              end
            end
            default: begin
              state_next = ST_STAT;
            end
          endcase
        end
      end
      ST_STAT: begin
        if (can_load) begin
          load       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_SKIP: begin
        ctrl.shift = 1'b1;
        skip_next  = skip - COUNT_W'(1);
        if (skip == COUNT_W'(1)) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (can_load) begin
          load        = 1'b1;
          load_sample = tap;
          load_data   = 1'b1;
          load_last   = (emit == COUNT_W'(1));
          ctrl.shift  = 1'b1;
          emit_next   = emit - COUNT_W'(1);
          // the last rotation brings the chain back to its home position
          if (emit == COUNT_W'(1)) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fill  <= '0;
      skip  <= '0;
      emit  <= '0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      skip  <= skip_next;
      emit  <= emit_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res.sample_out   <= load_sample;
      res.is_data      <= load_data;
      res.last_of_run  <= load_last;
      res.fill_level   <= fill;
      res.buffer_empty <= (fill == '0);
      res.buffer_full  <= (fill == CAP);
    end
  end

  assign res.valid = res_valid;

endmodule
`default_nettype wire

// ===== rtl/orwr_checker.sv =====
// port-level checks for the ring buffer unit and their bind
`timescale 1ns / 1ps
`default_nettype none
module orwr_checker
  import orwr_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                cmd_valid,
  input wire logic                cmd_ready,
  input wire logic                res_valid,
  input wire logic                res_ready,
  input wire logic [SAMPLE_W-1:0] sample_out,
  input wire logic                is_data,
  input wire logic                last_of_run,
  input wire logic [COUNT_W-1:0]  fill_level,
  input wire logic                buffer_empty,
  input wire logic                buffer_full
);

  // a stalled result keeps its payload
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(sample_out) &&
    $stable(is_data) && $stable(last_of_run) && $stable(fill_level))
    else $error("result changed while stalled");

  // the unit works on one item at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("item accepted while previous one still in progress");

  // flags agree with the fill level
  a_flags: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (buffer_empty == (fill_level == '0)) &&
    (buffer_full == (fill_level == COUNT_W'(CAPACITY))))
    else $error("status flags disagree with fill level");

  // status items close their run and carry no sample
  a_status_item: assert property (@(posedge clk) disable iff (rst)
    res_valid && !is_data |-> last_of_run && sample_out == '0)
    else $error("status item malformed");

  // data never comes from an empty buffer
  a_data_not_empty: assert property (@(posedge clk) disable iff (rst)
    res_valid && is_data |-> !buffer_empty)
    else $error("sample item from empty buffer");

endmodule

bind overwrite_ring_buffer_window_read_unit orwr_checker #(
  .CAPACITY (CAPACITY)
) u_orwr_checker (
  .clk          (clk),
  .rst          (rst),
  .cmd_valid    (cmd.valid),
  .cmd_ready    (cmd.ready),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .sample_out   (res.sample_out),
  .is_data      (res.is_data),
  .last_of_run  (res.last_of_run),
  .fill_level   (res.fill_level),
  .buffer_empty (res.buffer_empty),
  .buffer_full  (res.buffer_full)
);
`default_nettype wire
